### hw/rtl/ppbs_pkg.sv
`default_nettype none

package ppbs_pkg;

    typedef enum logic [2:0] {
        OP_EVEN    = 3'd0,
        OP_BLEND66 = 3'd1,
        OP_BLEND75 = 3'd2,
        OP_BLEND88 = 3'd3,
        OP_RATIO   = 3'd4,
        OP_FLASH   = 3'd5,
        OP_LIGHT   = 3'd6,
        OP_EXPAND  = 3'd7
    } opcode_t;

    typedef enum logic [2:0] {
        FM_NONE = 3'd0,
        FM_LVL1 = 3'd1,
        FM_LVL2 = 3'd2,
        FM_LVL3 = 3'd3,
        FM_LVL4 = 3'd4,
        FM_LVL5 = 3'd5,
        FM_LVL6 = 3'd6,
        FM_FULL = 3'd7
    } flash_mode_t;

    localparam logic [15:0] MASK_EVEN = 16'hFBDF;
    localparam logic [15:0] MASK_AVG  = 16'h7BDE;
    localparam logic [15:0] RND_HI    = 16'h2000;
    localparam logic [15:0] RND_MID   = 16'h0100;
    localparam logic [15:0] RND_LO    = 16'h0008;
    localparam logic [15:0] LIGHT_M4  = 16'h4210;
    localparam logic [15:0] LIGHT_M3  = 16'h6318;
    localparam logic [15:0] LIGHT_M2  = 16'h739C;
    localparam logic [15:0] LIGHT_M1  = 16'h7BDE;
    localparam logic [3:0]  LIGHT_PASS = 4'hF;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

    // One request as it sits in the first pipeline stage.
    typedef struct packed {
        opcode_t     opcode;
        logic [15:0] pix_a;
        logic [15:0] pix_b;
        logic [7:0]  ratio;
        flash_mode_t flash_mode;
        logic [7:0]  light_level;
    } item_t;

    // Load enables of the four pipeline stages.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } stage_en_t;

endpackage

`default_nettype wire

### hw/rtl/ppbs_in_if.sv
`default_nettype none

interface ppbs_in_if import ppbs_pkg::*; ();
    logic        valid;
    logic        ready;
    opcode_t     opcode;
    logic [15:0] pix_a;
    logic [15:0] pix_b;
    logic [7:0]  ratio;
    flash_mode_t flash_mode;
    logic [7:0]  light_level;

    modport source (
        output valid, opcode, pix_a, pix_b, ratio, flash_mode, light_level,
        input  ready
    );
    modport sink (
        input  valid, opcode, pix_a, pix_b, ratio, flash_mode, light_level,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/ppbs_out_if.sv
`default_nettype none

interface ppbs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;

    modport source (
        output valid, result,
        input  ready
    );
    modport sink (
        input  valid, result,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/ppbs_ctrl.sv
`default_nettype none

module ppbs_ctrl import ppbs_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output stage_en_t en
);

    // Bit 0 is the first stage, bit 3 the output register.
    logic [3:0] valid_reg;
    logic [3:0] valid_next;
    logic [3:0] rdy;

    always_comb
    begin
        // A stage may load when it is empty or its content moves on.
        rdy[3] = !valid_reg[3] || out_ready;
        rdy[2] = !valid_reg[2] || rdy[3];
        rdy[1] = !valid_reg[1] || rdy[2];
        rdy[0] = !valid_reg[0] || rdy[1];

        valid_next[0] = rdy[0] ? in_valid     : valid_reg[0];
        valid_next[1] = rdy[1] ? valid_reg[0] : valid_reg[1];
        valid_next[2] = rdy[2] ? valid_reg[1] : valid_reg[2];
        valid_next[3] = rdy[3] ? valid_reg[2] : valid_reg[3];

        en.ld1 = rdy[0];
        en.ld2 = rdy[1];
        en.ld3 = rdy[2];
        en.ld4 = rdy[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 4'b0000;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[3];

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] && !out_ready |-> !en.ld4)
        else $error("stalled result would be overwritten");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted request did not enter the first stage");

    a_stage1_kept: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] && !en.ld2 |=> valid_reg[0])
        else $error("request lost in the first stage");

    a_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] && en.ld4 |=> valid_reg[3])
        else $error("request lost on its way to the output register");
`endif

endmodule

`default_nettype wire

### hw/rtl/ppbs_wblend.sv
`default_nettype none

module ppbs_wblend import ppbs_pkg::*; (
    input  wire logic        clk,
    input  wire stage_en_t   en,
    input  wire item_t       item,
    output logic [15:0]      wres
);

    logic [7:0]  wa;
    logic [7:0]  wb;
    logic [13:0] pa_hi_reg, pb_hi_reg;
    logic [12:0] pa_mid_reg, pb_mid_reg;
    logic [12:0] pa_lo_reg, pb_lo_reg;
    logic        sh8_reg;
    logic [13:0] sum_hi;
    logic [12:0] sum_mid;
    logic [12:0] sum_lo;
    logic [23:0] hi_full, hi_sh;
    logic [17:0] mid_full, mid_sh;
    logic [13:0] lo_full, lo_sh;
    logic [15:0] wres_reg;
    logic [15:0] wres_next;

    always_comb
    begin
        case (item.opcode)
            OP_BLEND75:
            begin
                wa = 8'd12;
                wb = 8'd4;
            end
            OP_BLEND88:
            begin
                wa = 8'd14;
                wb = 8'd2;
            end
            default:
            begin
                wa = 8'hFF - item.ratio;
                wb = item.ratio;
            end
        endcase
    end

    // Stage two: per-field products, fields taken down to bit zero.
    always_ff @(posedge clk)
    begin
        if (en.ld2)
        begin
            pa_hi_reg  <= 14'(wa) * 14'(item.pix_a[15:10]);
            pb_hi_reg  <= 14'(wb) * 14'(item.pix_b[15:10]);
            pa_mid_reg <= 13'(wa) * 13'(item.pix_a[9:5]);
            pb_mid_reg <= 13'(wb) * 13'(item.pix_b[9:5]);
            pa_lo_reg  <= 13'(wa) * 13'(item.pix_a[4:0]);
            pb_lo_reg  <= 13'(wb) * 13'(item.pix_b[4:0]);
            sh8_reg    <= (item.opcode == OP_RATIO);
        end
    end

    // Stage three: put each field back in place, round, scale and mask.
    always_comb
    begin
        sum_hi    = pa_hi_reg + pb_hi_reg;
        sum_mid   = pa_mid_reg + pb_mid_reg;
        sum_lo    = pa_lo_reg + pb_lo_reg;
        hi_full   = {sum_hi, 10'b0} + 24'(RND_HI);
        mid_full  = {sum_mid, 5'b0} + 18'(RND_MID);
        lo_full   = {1'b0, sum_lo} + 14'(RND_LO);
        hi_sh     = sh8_reg ? (hi_full >> 8)  : (hi_full >> 4);
        mid_sh    = sh8_reg ? (mid_full >> 8) : (mid_full >> 4);
        lo_sh     = sh8_reg ? (lo_full >> 8)  : (lo_full >> 4);
        wres_next = {hi_sh[15:10], mid_sh[9:5], lo_sh[4:0]};
    end

    always_ff @(posedge clk)
    begin
        if (en.ld3)
        begin
            wres_reg <= wres_next;
        end
    end

    assign wres = wres_reg;

endmodule

`default_nettype wire

### hw/rtl/ppbs_tone.sv
`default_nettype none

module ppbs_tone import ppbs_pkg::*; (
    input  wire logic        clk,
    input  wire stage_en_t   en,
    input  wire item_t       item,
    output logic [15:0]      even_res,
    output logic [15:0]      flash_res,
    output logic [15:0]      light_res,
    output logic [23:0]      expand_res
);

    function automatic logic [15:0] even_blend(input logic [15:0] x, input logic [15:0] y);
        logic [16:0] s;
        s = {1'b0, x & MASK_EVEN} + {1'b0, y & MASK_EVEN};
        return s[16:1];
    endfunction

    function automatic logic [15:0] avg_blend(input logic [15:0] x, input logic [15:0] y);
        logic [15:0] s;
        s = (x & MASK_AVG) + (y & MASK_AVG);
        return s >> 1;
    endfunction

    function automatic logic [7:0] widen(input logic [4:0] c);
        return {c, c[4:2]};
    endfunction

    function automatic logic [7:0] brighten(input logic [7:0] e);
        logic [8:0] x;
        x = {1'b0, e} + {2'b0, e[7:1]};
        return x[8] ? 8'hFF : x[7:0];
    endfunction

    // Stage two registers
    opcode_t     op2_reg;
    flash_mode_t mode2_reg;
    logic [15:0] a2_reg, f2_reg;
    logic [15:0] e1_reg, t1_reg;
    logic [3:0]  shade_reg;
    logic [23:0] wide_reg;
    logic [7:0]  light_x3;
    logic [7:0]  light_w;

    // Stage three registers
    flash_mode_t mode3_reg;
    logic [15:0] a3_reg, f3_reg;
    logic [15:0] even_reg, t2_reg, light_reg;
    logic [23:0] expand_reg;
    logic [15:0] even_next, t2_next, light_next;

    always_comb
    begin
        // The light byte wraps modulo 256 on purpose.
        light_x3 = item.light_level + {item.light_level[6:0], 1'b0};
        light_w  = 8'hFF - light_x3;
    end

    always_ff @(posedge clk)
    begin
        if (en.ld2)
        begin
            op2_reg   <= item.opcode;
            mode2_reg <= item.flash_mode;
            a2_reg    <= item.pix_a;
            f2_reg    <= item.pix_b;
            e1_reg    <= even_blend(item.pix_a, item.pix_b);
            t1_reg    <= avg_blend(item.pix_a, item.pix_b);
            shade_reg <= light_w[7:4];
            wide_reg  <= {widen(item.pix_a[14:10]), widen(item.pix_a[9:5]),
                          widen(item.pix_a[4:0])};
        end
    end

    always_comb
    begin
        even_next = (op2_reg == OP_BLEND66) ? even_blend(a2_reg, e1_reg) : e1_reg;

        case (mode2_reg)
            FM_LVL1, FM_LVL2:         t2_next = avg_blend(a2_reg, t1_reg);
            FM_LVL3, FM_LVL5, FM_LVL6: t2_next = avg_blend(t1_reg, f2_reg);
            default:                  t2_next = t1_reg;
        endcase

        if (shade_reg == LIGHT_PASS)
        begin
            light_next = a2_reg;
        end
        else
        begin
            light_next = (shade_reg[0] ? ((a2_reg & LIGHT_M4) >> 4) : 16'h0000)
                       + (shade_reg[1] ? ((a2_reg & LIGHT_M3) >> 3) : 16'h0000)
                       + (shade_reg[2] ? ((a2_reg & LIGHT_M2) >> 2) : 16'h0000)
                       + (shade_reg[3] ? ((a2_reg & LIGHT_M1) >> 1) : 16'h0000);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.ld3)
        begin
            mode3_reg  <= mode2_reg;
            a3_reg     <= a2_reg;
            f3_reg     <= f2_reg;
            even_reg   <= even_next;
            t2_reg     <= t2_next;
            light_reg  <= light_next;
            expand_reg <= {brighten(wide_reg[23:16]), brighten(wide_reg[15:8]),
                           brighten(wide_reg[7:0])};
        end
    end

    // Last averaging level of the flash chain, ahead of the output register.
    always_comb
    begin
        case (mode3_reg)
            FM_NONE:          flash_res = a3_reg;
            FM_LVL1, FM_LVL3: flash_res = avg_blend(a3_reg, t2_reg);
            FM_LVL6:          flash_res = avg_blend(t2_reg, f3_reg);
            FM_FULL:          flash_res = f3_reg;
            default:          flash_res = t2_reg;
        endcase
    end

    assign even_res   = even_reg;
    assign light_res  = light_reg;
    assign expand_res = expand_reg;

endmodule

`default_nettype wire

### hw/rtl/packed_pixel_blend_shade_unit.sv
// Packed pixel blend and shade unit, four register stages.
// An accepted request moves from the first stage through stages two and three into
// the output register, where its result is offered on the response interface.
// Throughput: one request per cycle; a full pipeline moves only as the output
// register is drained, and empty stages fill in behind a stalled output.
// Reset clears the stage valid bits only; the datapath registers keep no reset.
`default_nettype none

module packed_pixel_blend_shade_unit import ppbs_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ppbs_in_if.sink    request,
    ppbs_out_if.source response
);

    stage_en_t   en;
    item_t       item_reg;
    item_t       item_next;
    opcode_t     op2_reg, op3_reg;
    logic [15:0] wres, even_res, flash_res, light_res;
    logic [23:0] expand_res;
    logic [31:0] result_reg;
    logic [31:0] result_next;

    ppbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (response.valid),
        .out_ready (response.ready),
        .en        (en)
    );

    always_comb
    begin
        item_next.opcode      = request.opcode;
        item_next.pix_a       = request.pix_a;
        item_next.pix_b       = request.pix_b;
        item_next.ratio       = request.ratio;
        item_next.flash_mode  = request.flash_mode;
        item_next.light_level = request.light_level;
    end

    always_ff @(posedge clk)
    begin
        if (en.ld1)
        begin
            item_reg <= item_next;
        end
        if (en.ld2)
        begin
            op2_reg <= item_reg.opcode;
        end
        if (en.ld3)
        begin
            op3_reg <= op2_reg;
        end
        if (en.ld4)
        begin
            result_reg <= result_next;
        end
    end

    ppbs_wblend u_wblend (
        .clk  (clk),
        .en   (en),
        .item (item_reg),
        .wres (wres)
    );

    ppbs_tone u_tone (
        .clk        (clk),
        .en         (en),
        .item       (item_reg),
        .even_res   (even_res),
        .flash_res  (flash_res),
        .light_res  (light_res),
        .expand_res (expand_res)
    );

    always_comb
    begin
        case (op3_reg)
            OP_EVEN, OP_BLEND66:              result_next = {16'h0000, even_res};
            OP_BLEND75, OP_BLEND88, OP_RATIO: result_next = {16'h0000, wres};
            OP_FLASH:                         result_next = {16'h0000, flash_res};
            OP_LIGHT:                         result_next = {16'h0000, light_res};
            default:                          result_next = {ALPHA_OPAQUE, expand_res};
        endcase
    end

    assign response.result = result_reg;

endmodule

`default_nettype wire
